[rtl/assert_macros.svh]
// Assertion helpers, included by bounded_stack_bottom_increment.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/bsbi_pkg.sv]
package bsbi_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned CAP_W   = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_INC  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_PUSH = 2'd1,
    CELL_POP  = 2'd2,
    CELL_INC  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [WORD_W-1:0] word;
  } cell_ctrl_t;

endpackage

[rtl/bounded_stack_bottom_increment.sv]
// A pop result appears on out_* in the cycle after the input transaction.
// Throughput: one operation per cycle unless stalled; cells shift, or add within the counted range, in parallel.
// Input stalls only while an earlier pop result waits for out_tready.
// Reset (rst_n low, synchronous): occupancy cleared, capacity set to 16,
// no result pending; stored words are left as they are.
module bounded_stack_bottom_increment #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,     // capacity
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,     // [31:0] operand_value, [47:32] bottom_count
  input  logic [1:0]  in_tuser,     // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,    // [31:0] popped_value
  output logic        out_tuser     // [0] was_empty
);
  import bsbi_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned OW = $clog2(DEPTH + 1);

  logic [CAP_W-1:0]   cap_r;
  logic [OW-1:0]      occ_r, occ_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]  out_data_r, out_data_nxt;
  logic               out_empty_r, out_empty_nxt;

  logic               accept;
  logic [WORD_W-1:0]  word;
  logic [COUNT_W-1:0] count;
  logic               can_push;
  logic               is_empty;
  logic [OW-1:0]      inc_n;
  logic [OW-1:0]      inc_lo;
  cell_ctrl_t         ctrl;
  logic [WORD_W-1:0]  cell_data [DEPTH];

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign word      = in_tdata[31:0];
  assign count     = in_tdata[47:32];

  assign can_push = (COUNT_W'(occ_r) < COUNT_W'(cap_r)) &&
                    (COUNT_W'(occ_r) < COUNT_W'(DEPTH));
  assign is_empty = (occ_r == '0);
  // Clamp the count to the occupancy; bottom words sit at [occ-n, occ).
  assign inc_n    = (count < COUNT_W'(occ_r)) ? OW'(count) : occ_r;
  assign inc_lo   = occ_r - inc_n;

  always_comb begin
    ctrl.word = word;
    ctrl.op   = CELL_HOLD;
    occ_nxt   = occ_r;
    if (accept) begin
      case (in_tuser)
        MODE_PUSH: begin
          if (can_push) begin
            ctrl.op = CELL_PUSH;
            occ_nxt = occ_r + 1'b1;
          end
        end
        MODE_POP: begin
          if (!is_empty) begin
            ctrl.op = CELL_POP;
            occ_nxt = occ_r - 1'b1;
          end
        end
        MODE_INC:  ctrl.op = CELL_INC;
        default:   ctrl.op = CELL_HOLD;
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] above;
    logic [WORD_W-1:0] below;
    if (i == 0) begin : g_top
      assign above = word;
    end else begin : g_mid
      assign above = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign below = cell_data[i];
    end else begin : g_inner
      assign below = cell_data[i+1];
    end
    bsbi_cell #(
      .OW  (OW),
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .inc_lo     (inc_lo),
      .occ        (occ_r),
      .above_data (above),
      .below_data (below),
      .data       (cell_data[i])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_empty_nxt = out_empty_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept && (in_tuser == MODE_POP)) begin
      out_valid_nxt = 1'b1;
      out_empty_nxt = is_empty;
      out_data_nxt  = is_empty ? '0 : cell_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_empty_r;

  `ASSERT_ALWAYS(a_occ_bound, COUNT_W'(occ_r) <= COUNT_W'(DEPTH), "occupancy above depth")
  `ASSERT_NEXT(a_pop_result, accept && (in_tuser == MODE_POP), out_tvalid, "pop gave no result")
  `ASSERT_NEXT(a_push_grow, accept && (in_tuser == MODE_PUSH) && can_push,
               occ_r == $past(occ_r) + 1'b1, "push did not grow the stack")
  `ASSERT_NEXT(a_empty_flag, accept && (in_tuser == MODE_POP) && is_empty,
               out_tuser && (out_tdata == '0), "empty pop lost its flag")

endmodule

[rtl/bsbi_cell.sv]
module bsbi_cell #(
  parameter int unsigned OW  = 5,
  parameter int unsigned IDX = 0
) (
  input  logic                  clk,
  input  bsbi_pkg::cell_ctrl_t  ctrl,
  input  logic [OW-1:0]         inc_lo,
  input  logic [OW-1:0]         occ,
  input  logic [31:0]           above_data,
  input  logic [31:0]           below_data,
  output logic [31:0]           data
);
  import bsbi_pkg::*;

  logic [WORD_W-1:0] data_r;
  logic [WORD_W-1:0] data_nxt;
  logic              in_range;

  // Cell 0 holds the top; stack depth grows toward higher indexes.
  assign in_range = (OW'(IDX) >= inc_lo) && (OW'(IDX) < occ);

  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      CELL_PUSH: data_nxt = above_data;
      CELL_POP:  data_nxt = below_data;
      CELL_INC: begin
        if (in_range) begin
          data_nxt = data_r + ctrl.word;
        end
      end
      default:   data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

[tb/bounded_stack_bottom_increment_tb.sv]
module bounded_stack_bottom_increment_tb;
  import bsbi_pkg::*;

  localparam int unsigned STACK_DEPTH = 16;
  localparam logic [1:0]  MODE_NOP    = 2'd3;  // unused code: no operation
  localparam int unsigned HOLD_AT     = 250;   // operations accepted before the long stall
  localparam int unsigned HOLD_LEN    = 300;   // countdown that sets the length of the long stall

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] operand;
    logic [15:0] count;
  } stack_op_t;

  typedef struct {
    logic [31:0] value;
    logic        empty;
  } pop_result_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data   = CAP_RESET;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;  // [31:0] operand_value, [47:32] bottom_count
  logic [1:0]  in_tuser   = '0;  // [1:0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;        // [31:0] popped_value
  logic        out_tuser;        // [0] was_empty

  stack_op_t   pending_ops[$];
  pop_result_t expected_pops[$];
  stack_op_t   drive_op;

  // Predicted stack contents and capacity
  logic [31:0] stack_words [STACK_DEPTH];
  int unsigned stack_fill;
  logic [4:0]  capacity_reg;

  int unsigned ops_accepted;
  int unsigned mismatches     = 0;
  int unsigned send_gap_pct   = 11;
  int unsigned recv_stall_pct = 58;
  int unsigned hold_left;
  logic        hold_done;

  int unsigned capacity_plan [3][3] = '{'{31, 16, 1}, '{5, 0, 12}, '{16, 2, 31}};

  bounded_stack_bottom_increment #(
    .DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("bounded_stack_bottom_increment_tb: done, errors");
    $finish;
  end

  task automatic report_mismatch(string what);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic apply_stack_op(logic [1:0] mode, logic [31:0] operand, logic [15:0] count);
    int unsigned limit;
    int unsigned n;
    pop_result_t res;
    limit = (capacity_reg < STACK_DEPTH) ? capacity_reg : STACK_DEPTH;
    case (mode)
      MODE_PUSH: begin
        // drop silently when full
        if (stack_fill < limit) begin
          stack_words[stack_fill] = operand;
          stack_fill++;
        end
      end
      MODE_POP: begin
        if (stack_fill == 0) begin
          res.value = '0;
          res.empty = 1'b1;
        end else begin
          stack_fill--;
          res.value = stack_words[stack_fill];
          res.empty = 1'b0;
        end
        expected_pops.push_back(res);
      end
      MODE_INC: begin
        n = (count < stack_fill) ? count : stack_fill;
        for (int i = 0; i < n; i++)
          stack_words[i] = stack_words[i] + operand;
      end
      default: ;
    endcase
  endtask

  task automatic check_pop_result(logic [31:0] value, logic empty);
    pop_result_t want;
    if (expected_pops.size() == 0) begin
      report_mismatch($sformatf("unexpected pop result %h empty %b", value, empty));
      return;
    end
    want = expected_pops.pop_front();
    if (value !== want.value)
      report_mismatch($sformatf("popped_value %h, want %h", value, want.value));
    if (empty !== want.empty)
      report_mismatch($sformatf("was_empty %b, want %b", empty, want.empty));
  endtask

  // Driver: present the next pending operation, with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        drive_op = pending_ops.pop_front();
        in_tdata  <= {drive_op.count, drive_op.operand};
        in_tuser  <= drive_op.mode;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!hold_done && ops_accepted >= HOLD_AT) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_LEN;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: track configuration, check results, predict from accepted operations
  always @(posedge clk) begin
    if (!rst_n) begin
      stack_fill   = 0;
      capacity_reg = CAP_RESET;
      ops_accepted <= 0;
      expected_pops.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        capacity_reg = cfg_data;
      if (out_tvalid && out_tready)
        check_pop_result(out_tdata, out_tuser);
      if (in_tvalid && in_tready) begin
        apply_stack_op(in_tuser, in_tdata[31:0], in_tdata[47:32]);
        ops_accepted <= ops_accepted + 1;
      end
    end
  end

  task automatic add_op(logic [1:0] mode, logic [31:0] operand, logic [15:0] count);
    stack_op_t op;
    op.mode    = mode;
    op.operand = operand;
    op.count   = count;
    pending_ops.push_back(op);
  endtask

  // Hold until every operation is sent and every pop result has arrived
  task automatic wait_drained();
    do
      @(negedge clk);
    while (pending_ops.size() != 0 || in_tvalid || expected_pops.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_capacity(logic [4:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do
      @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Bursts that lean toward filling, draining or mixing, so the stack
  // regularly reaches both full and empty
  task automatic queue_random_ops(int unsigned n_ops);
    int unsigned queued;
    int unsigned burst_left;
    int unsigned burst_kind;
    int unsigned roll;
    stack_op_t op;
    queued     = 0;
    burst_left = 0;
    burst_kind = 0;
    while (queued < n_ops) begin
      if (burst_left == 0) begin
        burst_kind = $urandom_range(2);
        burst_left = $urandom_range(30, 4);
      end
      burst_left--;
      case ($urandom_range(7))
        0:       op.operand = 32'h7FFF_FFFF;
        1:       op.operand = 32'h8000_0000;
        2:       op.operand = 32'hFFFF_FFFF;
        3:       op.operand = $urandom_range(3);
        default: op.operand = $urandom;
      endcase
      case ($urandom_range(9))
        0:       op.count = '0;
        1:       op.count = 16'hFFFF;
        2:       op.count = 16'($urandom);
        default: op.count = 16'($urandom_range(20));
      endcase
      roll = $urandom_range(99);
      if (roll < 3) begin
        op.mode = MODE_NOP;
      end else begin
        roll = $urandom_range(99);
        case (burst_kind)
          0:       op.mode = (roll < 70) ? MODE_PUSH : (roll < 85) ? MODE_POP : MODE_INC;
          1:       op.mode = (roll < 70) ? MODE_POP : (roll < 85) ? MODE_PUSH : MODE_INC;
          default: op.mode = (roll < 40) ? MODE_PUSH : (roll < 75) ? MODE_POP : MODE_INC;
        endcase
      end
      pending_ops.push_back(op);
      if (op.mode != MODE_NOP)
        queued++;
    end
  endtask

  initial begin
    wait (rst_n);
    @(negedge clk);

    // Empty stack, wrap-around on increment, count clamping, unused code
    add_op(MODE_POP, '0, '0);
    add_op(MODE_INC, 32'd5, 16'd3);
    add_op(MODE_PUSH, 32'h7FFF_FFFF, 16'hFFFF);
    add_op(MODE_PUSH, 32'h8000_0000, '0);
    add_op(MODE_PUSH, 32'hFFFF_FFFF, '0);
    add_op(MODE_PUSH, '0, '0);
    add_op(MODE_INC, 32'd1, '0);
    add_op(MODE_INC, 32'd1, 16'hFFFF);
    add_op(MODE_INC, 32'h8000_0000, 16'd2);
    add_op(MODE_NOP, 32'hFFFF_FFFF, 16'hFFFF);
    repeat (5) add_op(MODE_POP, '0, '0);
    wait_drained();

    // Fill to capacity, then push into a full stack
    set_capacity(5'd4);
    for (int i = 0; i < 5; i++)
      add_op(MODE_PUSH, 32'h1000_0000 + i, '0);
    wait_drained();

    // Capacity lowered below occupancy: words kept, pushes dropped
    set_capacity(5'd2);
    add_op(MODE_PUSH, 32'hDEAD_BEEF, '0);
    add_op(MODE_INC, 32'hFFFF_FFFD, 16'd3);
    repeat (5) add_op(MODE_POP, '0, '0);
    wait_drained();

    set_capacity(5'd1);
    add_op(MODE_PUSH, 32'h5555_5555, '0);
    add_op(MODE_PUSH, 32'hAAAA_AAAA, '0);
    add_op(MODE_POP, '0, '0);
    add_op(MODE_POP, '0, '0);
    wait_drained();

    // Capacity zero accepts no push
    set_capacity(5'd0);
    add_op(MODE_PUSH, 32'h1234_5678, '0);
    add_op(MODE_POP, '0, '0);
    wait_drained();

    for (int s = 0; s < 3; s++) begin
      case (s)
        0: begin
          send_gap_pct   = 11;
          recv_stall_pct = 58;
        end
        1: begin
          send_gap_pct   = 58;
          recv_stall_pct = 11;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int c = 0; c < 3; c++) begin
        set_capacity(5'(capacity_plan[s][c]));
        queue_random_ops(190);
        wait_drained();
      end
    end

    repeat (5) @(negedge clk);
    if (mismatches == 0)
      $display("bounded_stack_bottom_increment_tb: done, clean");
    else
      $display("bounded_stack_bottom_increment_tb: done, errors");
    $finish;
  end

endmodule
